/* design/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bump and first-fit allocator: default
// sizes, register reset values and indexes, request and status codes, rounding unit result.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    // default sizes
    localparam int FRAGMENTS_DEF   = 16;
    localparam int ALIGN_BYTES_DEF = 8;

    // register reset values
    localparam logic [31:0] REGION_BASE_RST = 32'd0;
    localparam logic [31:0] REGION_END_RST  = 32'(4 * 1024 * 1024);

    // configuration register indexes
    localparam logic CFG_REGION_BASE = 1'b0;
    localparam logic CFG_REGION_END  = 1'b1;

    // request types
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_BUMP    = 3'd0;
    localparam logic [2:0] STAT_FRAG    = 3'd1;
    localparam logic [2:0] STAT_COLLECT = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_ACK     = 3'd4;

    // rounding unit result: bit 32 of rounded marks overflow
    typedef struct packed {
        logic        done;
        logic [32:0] rounded;
    } bfa_round_res_t;

endpackage

`default_nettype wire

/* design/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, available in the cycle after the read address is applied.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/bfa_round.sv */
// ----------------------------------------------------------------------------
// bfa_round
// Rounds a byte count up to a multiple of ALIGN_BYTES. The quotient comes from
// a multiplication by a constant reciprocal, the remainder from it, and the
// padding is added in a third stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_round
    import bfa_pkg::*;
#(
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] bytes_in,
    output bfa_round_res_t   res
);

    localparam int RW    = $clog2(ALIGN_BYTES) + 1;
    // rounded-up reciprocal, exact quotient for every 32-bit count
    localparam int SHIFT = 32 + $clog2(ALIGN_BYTES);
    localparam logic [32:0] RECIP =
        33'(((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
    localparam logic [RW-1:0] ALIGN_W = RW'(ALIGN_BYTES);

    logic           mul_vld_reg, mul_vld_next;
    logic           sub_vld_reg, sub_vld_next;
    logic           pad_vld_reg, pad_vld_next;
    logic           done_reg, done_next;
    logic [31:0]    bytes_reg, bytes_next;
    logic [31:0]    quot_reg, quot_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [32:0]    rounded_reg, rounded_next;
    logic [64:0]    product;

    // quotient estimate by reciprocal multiplication
    assign product = 65'(bytes_reg) * 65'(RECIP);

    // stage sequencing and datapath
    always_comb begin
        mul_vld_next = start;
        sub_vld_next = mul_vld_reg;
        pad_vld_next = sub_vld_reg;
        done_next    = pad_vld_reg;
        bytes_next   = bytes_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        rounded_next = rounded_reg;
        if (start) begin
            bytes_next = bytes_in;
        end
        if (mul_vld_reg) begin
            quot_next = 32'(product >> SHIFT);
        end
        if (sub_vld_reg) begin
            // only the low bits matter, the remainder is below ALIGN_BYTES
            rem_next = bytes_reg[RW-1:0] - quot_reg[RW-1:0] * ALIGN_W;
        end
        if (pad_vld_reg) begin
            if (rem_reg == '0) begin
                rounded_next = {1'b0, bytes_reg};
            end else begin
                rounded_next = {1'b0, bytes_reg} + 33'(ALIGN_W - rem_reg);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            sub_vld_reg <= 1'b0;
            pad_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            mul_vld_reg <= mul_vld_next;
            sub_vld_reg <= sub_vld_next;
            pad_vld_reg <= pad_vld_next;
            done_reg    <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        bytes_reg   <= bytes_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        rounded_reg <= rounded_next;
    end

    assign res.done    = done_reg;
    assign res.rounded = rounded_reg;

endmodule

`default_nettype wire

/* design/bump_and_first_fit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bump_and_first_fit_allocator_unit
// Allocator that serves requests from a bump pointer and, failing that,
// first-fit from a table of free fragments held in a RAM.
//
// Usage:
//   s_* carries one request per transfer (allocate, append fragment,
//   restart); m_* returns exactly one status and address per request.
//   cfg_* writes region_base (index 0) and region_end (index 1); the user
//   must do so only while idle, which the block itself does not enforce.
//   region_base is taken into the bump pointer at the next restart.
// Append, restart and unused types go from idle straight to the response
// state. An allocate passes the three-stage rounding unit (reciprocal
// multiply, remainder, padding add) and a bump check that answers when
// served by bump, on rounding overflow or with an empty table; else a
// fragment scan reads entries through the one-read-a-cycle RAM port (up
// to FRAGMENTS), and retiring an emptied fragment moves later entries down.
// One request is worked on at a time; s_ready is high only between requests.
// A finished result sits in the output register, so the next request is
// taken while the receiver stalls; a later result waits for the slot.
// Reset empties the fragment table and sets the bump pointer to the base
// reset value; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_and_first_fit_allocator_unit
    import bfa_pkg::*;
#(
    parameter int FRAGMENTS   = FRAGMENTS_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [31:0] s_request_bytes,
    input  wire logic [31:0] s_fragment_start,
    input  wire logic [31:0] s_fragment_bytes,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_address
);

    localparam int IW = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
    localparam int CW = $clog2(FRAGMENTS + 1);
    localparam logic [CW:0] FRAG_LIMIT = (CW + 1)'(FRAGMENTS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_BUMP  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [31:0]    bump_reg, bump_next;
    logic [31:0]    base_reg, base_next;
    logic [31:0]    end_reg, end_next;
    logic [2:0]     resp_status_reg, resp_status_next;
    logic [31:0]    resp_addr_reg, resp_addr_next;
    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_status_reg, m_status_next;
    logic [31:0]    m_address_reg, m_address_next;

    logic           accept;
    logic           round_start;
    bfa_round_res_t round_res;
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic [63:0]    ram_wdata;
    logic [IW-1:0]  ram_raddr;
    logic [63:0]    ram_rdata;

    logic [31:0]    rd_start;
    logic [31:0]    rd_size;
    logic [31:0]    need;
    logic [32:0]    bump_sum;
    logic [CW:0]    idx_plus1;
    logic [CW:0]    idx_plus2;
    logic           frag_fits;
    logic           frag_empties;
    logic           out_free;

    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign round_start = accept && (s_req_type == REQ_ALLOC);

    assign rd_start     = ram_rdata[63:32];
    assign rd_size      = ram_rdata[31:0];
    assign need         = round_res.rounded[31:0];
    assign bump_sum     = {1'b0, bump_reg} + {1'b0, need};
    assign idx_plus1    = {1'b0, idx_reg} + 1'b1;
    assign idx_plus2    = {1'b0, idx_reg} + 2'd2;
    assign frag_fits    = (rd_size >= need);
    assign frag_empties = (rd_size == need);
    assign out_free     = !m_valid_reg || m_ready;

    // rounding unit
    bfa_round #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (round_start),
        .bytes_in (s_request_bytes),
        .res      (round_res)
    );

    // fragment table: start in the upper half, size in the lower
    bfa_ram #(
        .WIDTH (64),
        .DEPTH (FRAGMENTS)
    ) u_frag_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // read address: first entry, next entry in a scan, entry after next in a move
    always_comb begin
        case (state_reg)
            S_SCAN:  ram_raddr = idx_plus1[IW-1:0];
            S_SHIFT: ram_raddr = idx_plus2[IW-1:0];
            default: ram_raddr = '0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        bump_next        = bump_reg;
        base_next        = base_reg;
        end_next         = end_reg;
        resp_status_next = resp_status_reg;
        resp_addr_next   = resp_addr_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[IW-1:0];
        ram_wdata        = ram_rdata;

        // register writes
        if (cfg_wr_en) begin
            if (cfg_index == CFG_REGION_BASE) begin
                base_next = cfg_wr_data;
            end else begin
                end_next = cfg_wr_data;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    resp_status_next = STAT_ACK;
                    resp_addr_next   = '0;
                    state_next       = S_RESP;
                    case (s_req_type)
                        REQ_ALLOC: begin
                            state_next = S_ROUND;
                        end
                        REQ_APPEND: begin
                            if ({1'b0, count_reg} >= FRAG_LIMIT) begin
                                resp_status_next = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IW-1:0];
                                ram_wdata  = {s_fragment_start, s_fragment_bytes};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_RESTART: begin
                            count_next = '0;
                            bump_next  = base_reg;
                        end
                        default: begin
                            resp_status_next = STAT_ACK;
                        end
                    endcase
                end
            end
            S_ROUND: begin
                if (round_res.done) begin
                    state_next = S_BUMP;
                end
            end
            S_BUMP: begin
                // the read of entry 0 is under way here
                idx_next = '0;
                if (round_res.rounded[32]) begin
                    resp_status_next = STAT_COLLECT;
                    state_next       = S_RESP;
                end else if (bump_sum <= {1'b0, end_reg}) begin
                    resp_status_next = STAT_BUMP;
                    resp_addr_next   = bump_reg;
                    bump_next        = bump_sum[31:0];
                    state_next       = S_RESP;
                end else if (count_reg == '0) begin
                    resp_status_next = STAT_COLLECT;
                    state_next       = S_RESP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (frag_fits) begin
                    resp_status_next = STAT_FRAG;
                    resp_addr_next   = rd_start;
                    if (!frag_empties) begin
                        // shrink the fragment in place
                        ram_we     = 1'b1;
                        ram_wdata  = {rd_start + need, rd_size - need};
                        state_next = S_RESP;
                    end else if (idx_plus1 < {1'b0, count_reg}) begin
                        // retire: later entries move down one place
                        state_next = S_SHIFT;
                    end else begin
                        count_next = count_reg - 1'b1;
                        state_next = S_RESP;
                    end
                end else if (idx_plus1 >= {1'b0, count_reg}) begin
                    resp_status_next = STAT_COLLECT;
                    resp_addr_next   = '0;
                    state_next       = S_RESP;
                end else begin
                    idx_next = idx_plus1[CW-1:0];
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (idx_plus2 < {1'b0, count_reg}) begin
                    idx_next = idx_plus1[CW-1:0];
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_address_next = m_address_reg;
        if (state_reg == S_RESP && out_free) begin
            m_valid_next   = 1'b1;
            m_status_next  = resp_status_reg;
            m_address_next = resp_addr_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            bump_reg    <= REGION_BASE_RST;
            base_reg    <= REGION_BASE_RST;
            end_reg     <= REGION_END_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            bump_reg    <= bump_next;
            base_reg    <= base_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        resp_status_reg <= resp_status_next;
        resp_addr_reg   <= resp_addr_next;
        m_status_reg    <= m_status_next;
        m_address_reg   <= m_address_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;

endmodule

`default_nettype wire

/* design/bfa_checker.sv */
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the allocator: reset behaviour, one request in flight,
// zero address on unserved results, result held while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_checker
    import bfa_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_address
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a request is worked on alone: no transfer in the cycle after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // unserved results carry a zero address
    a_zero_address: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_BUMP && m_status != STAT_FRAG |-> m_address == '0)
        else $error("nonzero address on unserved result");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_address))
        else $error("result changed while stalled");

endmodule

bind bump_and_first_fit_allocator_unit bfa_checker u_bfa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_address (m_address)
);

`default_nettype wire
